>>> sv/triangle_unit_normal_unit_assert.svh
// Assertion macros for the triangle unit normal block.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH
// Check that a condition implies a consequence on the same edge.
`define TUN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define TUN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/tun_pkg.sv
// Shared constants and types for the triangle unit normal block.
package tun_pkg;
  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int NormWidth  = FracBits + 2;
  localparam int EdgeWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * EdgeWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int MagWidth   = CrossWidth - 1;
  localparam int HalfWidth  = MagWidth / 2;
  localparam int PartWidth  = 2 * HalfWidth;
  localparam int SqWidth    = 2 * MagWidth + 2;
  localparam int RootWidth  = SqWidth / 2;
  localparam int RemWidth   = MagWidth + FracBits + 1;
  localparam int QuotWidth  = FracBits + 1;
  localparam int InBytes    = (9 * CoordWidth + 7) / 8;
  localparam int OutBytes   = (3 * NormWidth + 7) / 8;

  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic [MagWidth-1:0]          mag_t;
  typedef logic [HalfWidth-1:0]         half_t;
  typedef logic [PartWidth-1:0]         part_t;
  typedef logic [SqWidth-1:0]           sq_t;
  typedef logic [RootWidth-1:0]         root_t;
  typedef logic [RemWidth-1:0]          rem_t;
  typedef logic [QuotWidth-1:0]         quot_t;
  typedef logic signed [NormWidth-1:0]  norm_t;

  // State of one root-extraction step.
  typedef struct packed {
    sq_t   rem;
    root_t root;
  } sqrt_st_t;

  // State of one division step for one component.
  typedef struct packed {
    rem_t  rem;
    quot_t quot;
    logic  neg;
  } div_st_t;
endpackage

>>> sv/tun_sqrt_stage.sv
// One registered stage of the restoring integer square root (several bits per stage).
module tun_sqrt_stage (
  input  logic                clk,
  input  logic                adv,
  input  int unsigned         hi_bit,
  input  tun_pkg::sqrt_st_t   st_in,
  output tun_pkg::sqrt_st_t   st_out
);
  import tun_pkg::*;
  sqrt_st_t st_nxt;
  sqrt_st_t st_r;

  // Try each root bit from hi_bit down, four per stage.
  always_comb begin
    sq_t   trial;
    sqrt_st_t s;
    int    b;
    s = st_in;
    for (int k = 0; k < 4; k++) begin
      b = int'(hi_bit) - k;
      if (b >= 0) begin
        trial = (SqWidth'(s.root) << (b + 1)) | (SqWidth'(1) << (2 * b));
        if (trial <= s.rem) begin
          s.rem  = s.rem - trial;
          s.root = s.root | (RootWidth'(1) << b);
        end
      end
    end
    st_nxt = s;
  end

  // Hold on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end
  assign st_out = st_r;
endmodule

>>> sv/triangle_unit_normal_unit.sv
// Triangle unit normal: deep pipeline with edges, cross product, square, sqrt and divide.
// Throughput: one triangle per cycle; every stage advances when the output register
// is empty or its word is taken, so a stall holds each stage in place.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module triangle_unit_normal_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each, lowest first)
  input  logic [8*tun_pkg::InBytes-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // norm_x, norm_y, norm_z (18 bits each, lowest first), zero fill
  output logic [8*tun_pkg::OutBytes-1:0] out_tdata,
  // degenerate
  output logic                         out_tuser
);
  import tun_pkg::*;
  `include "triangle_unit_normal_unit_assert.svh"

  localparam int SqrtSt = (RootWidth + 3) / 4;
  localparam int DivSt  = (QuotWidth + 3) / 4;
  localparam int NVal   = 6 + SqrtSt + DivSt;

  logic adv;
  logic [NVal-1:0] vld_r;

  assign adv       = !vld_r[NVal-1] || out_tready;
  assign in_tready = adv;

  // Advance valid bits through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NVal-2:0], in_tvalid};
    end
  end

  // Stage 0: edge vectors.
  logic signed [EdgeWidth-1:0] e1_r [3];
  logic signed [EdgeWidth-1:0] e2_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EdgeWidth'($signed(in_tdata[(3+i)*CoordWidth +: CoordWidth]))
                 - EdgeWidth'($signed(in_tdata[i*CoordWidth +: CoordWidth]));
        e2_r[i] <= EdgeWidth'($signed(in_tdata[(6+i)*CoordWidth +: CoordWidth]))
                 - EdgeWidth'($signed(in_tdata[i*CoordWidth +: CoordWidth]));
      end
    end
  end

  // Stage 1: six products of the cross terms.
  logic signed [ProdWidth-1:0] pa_r [3];
  logic signed [ProdWidth-1:0] pb_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r[0] <= e1_r[1] * e2_r[2];
      pb_r[0] <= e1_r[2] * e2_r[1];
      pa_r[1] <= e1_r[2] * e2_r[0];
      pb_r[1] <= e1_r[0] * e2_r[2];
      pa_r[2] <= e1_r[0] * e2_r[1];
      pb_r[2] <= e1_r[1] * e2_r[0];
    end
  end

  // Stage 2: cross product, magnitudes.
  cross_t cr_r [3];
  mag_t   mg_r [3];
  always_ff @(posedge clk) begin
    cross_t c;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c = CrossWidth'(pa_r[i]) - CrossWidth'(pb_r[i]);
        cr_r[i] <= c;
        mg_r[i] <= c[CrossWidth-1] ? MagWidth'(-c) : MagWidth'(c);
      end
    end
  end

  // Stage 3: partial squares from the high and low halves of each magnitude.
  part_t hh_r [3];
  part_t hl_r [3];
  part_t ll_r [3];
  logic  ng_s3_r [3];
  mag_t  mg_s3_r [3];
  always_ff @(posedge clk) begin
    half_t hi;
    half_t lo;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hi = mg_r[i][MagWidth-1:HalfWidth];
        lo = mg_r[i][HalfWidth-1:0];
        hh_r[i]    <= PartWidth'(hi) * PartWidth'(hi);
        hl_r[i]    <= PartWidth'(hi) * PartWidth'(lo);
        ll_r[i]    <= PartWidth'(lo) * PartWidth'(lo);
        ng_s3_r[i] <= cr_r[i][CrossWidth-1];
        mg_s3_r[i] <= mg_r[i];
      end
    end
  end

  // Stage 4: squared length from the aligned partial squares.
  sq_t  s_r;
  logic ng_s4_r [3];
  mag_t mg_s4_r [3];
  always_ff @(posedge clk) begin
    sq_t acc;
    if (adv) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        acc = acc + (SqWidth'(hh_r[i]) << (2 * HalfWidth))
                  + (SqWidth'(hl_r[i]) << (HalfWidth + 1))
                  + SqWidth'(ll_r[i]);
        ng_s4_r[i] <= ng_s3_r[i];
        mg_s4_r[i] <= mg_s3_r[i];
      end
      s_r <= acc;
    end
  end

  // Square root stages, with magnitudes and signs carried alongside.
  sqrt_st_t sq_st [SqrtSt+1];
  logic     ng_q  [SqrtSt+1][3];
  mag_t     mg_q  [SqrtSt+1][3];
  logic     dg_q  [SqrtSt+1];
  assign sq_st[0] = '{rem: s_r, root: '0};
  assign dg_q[0]  = (s_r == '0);
  for (genvar i = 0; i < 3; i++) begin : g_c0
    assign ng_q[0][i] = ng_s4_r[i];
    assign mg_q[0][i] = mg_s4_r[i];
  end
  for (genvar k = 0; k < SqrtSt; k++) begin : g_sqrt
    tun_sqrt_stage u_st (
      .clk(clk), .adv(adv), .hi_bit(RootWidth - 1 - 4 * k),
      .st_in(sq_st[k]), .st_out(sq_st[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        dg_q[k+1] <= dg_q[k];
        for (int i = 0; i < 3; i++) begin
          ng_q[k+1][i] <= ng_q[k][i];
          mg_q[k+1][i] <= mg_q[k][i];
        end
      end
    end
  end

  // Division stages: restoring, four quotient bits per stage.
  div_st_t dv [DivSt+1][3];
  root_t   ln [DivSt+1];
  logic    dg_d [DivSt+1];
  assign ln[0]   = sq_st[SqrtSt].root;
  assign dg_d[0] = dg_q[SqrtSt];
  for (genvar i = 0; i < 3; i++) begin : g_d0
    assign dv[0][i] = '{rem: RemWidth'(mg_q[SqrtSt][i]) << FracBits, quot: '0,
                        neg: ng_q[SqrtSt][i]};
  end
  for (genvar k = 0; k < DivSt; k++) begin : g_div
    div_st_t dn [3];
    always_comb begin
      rem_t t;
      int   b;
      for (int i = 0; i < 3; i++) begin
        dn[i] = dv[k][i];
        for (int j = 0; j < 4; j++) begin
          b = FracBits - 4 * k - j;
          if (b >= 0) begin
            t = RemWidth'(ln[k]) << b;
            if (t <= dn[i].rem) begin
              dn[i].rem  = dn[i].rem - t;
              dn[i].quot = dn[i].quot | (QuotWidth'(1) << b);
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ln[k+1]   <= ln[k];
        dg_d[k+1] <= dg_d[k];
        for (int i = 0; i < 3; i++) dv[k+1][i] <= dn[i];
      end
    end
  end

  // Output register: apply sign, force zero when degenerate.
  norm_t nrm_r [3];
  logic  dgo_r;
  always_ff @(posedge clk) begin
    norm_t q;
    if (adv) begin
      dgo_r <= dg_d[DivSt];
      for (int i = 0; i < 3; i++) begin
        q = norm_t'(dv[DivSt][i].quot);
        nrm_r[i] <= dg_d[DivSt] ? '0 : (dv[DivSt][i].neg ? -q : q);
      end
    end
  end

  assign out_tvalid = vld_r[NVal-1];
  assign out_tuser  = dgo_r;
  assign out_tdata  = (8*OutBytes)'({nrm_r[2], nrm_r[1], nrm_r[0]});

  `TUN_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid,
    "output word dropped under stall")
  `TUN_ASSERT_IMP(a_deg_zero, clk, rst_n, out_tvalid && out_tuser,
    out_tdata == '0, "degenerate word carries nonzero normal")
  `TUN_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready,
    "input stalled with empty output")
endmodule
